// ===== hw/rtl/bfb_pkg.sv =====
// Shared types, register codes and constants of the bisync frame builder.
package bfb_pkg;

    // Frame geometry
    localparam int FRAME_CAPACITY = 98;
    localparam int TERM_MAX       = 8;
    localparam int FC_W           = 7;
    localparam int TERM_N_W       = 4;
    localparam int TOTAL_W        = 5;

    // Header lengths and control characters
    localparam logic [2:0] HDR_LEN_PLAIN = 3'd5;
    localparam logic [2:0] HDR_LEN_CHECK = 3'd6;
    localparam logic [7:0] CHR_EOT       = 8'h04;
    localparam logic [7:0] CHR_STX       = 8'h02;
    localparam logic [7:0] CHR_ZERO      = 8'h30;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GROUP_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_BYTES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 3'd5;

    // Input item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_last;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       overflow;
    } t_out_item;

    // Which part of the frame a byte comes from
    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_PAY,
        SEL_TERM,
        SEL_CHK
    } t_sel;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                emit;
        t_sel                sel;
        logic [2:0]          idx;
        logic                final_byte;
        logic                commit;
    } t_cmd;

    // Datapath to controller: byte counts of the current step
    typedef struct packed {
        logic [2:0]          hdr_n;
        logic                pay_n;
        logic [TERM_N_W-1:0] term_n;
        logic                chk_n;
        logic [TOTAL_W-1:0]  total;
    } t_status;

endpackage

// ===== hw/rtl/bfb_datapath.sv =====
// Datapath: configuration, frame state, step planning and byte selection.
module bfb_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  bfb_pkg::t_in_item               i_in_data,
    input  bfb_pkg::t_cmd                   i_cmd,
    output bfb_pkg::t_status                o_status,
    output bfb_pkg::t_out_item              o_out_data
);
    import bfb_pkg::*;

    localparam logic [FC_W-1:0] CAP = FC_W'(FRAME_CAPACITY);

    // Configuration registers
    logic [3:0]            r_group;
    logic [3:0]            r_local;
    logic                  r_mode;
    logic [3:0]            r_term_len;
    logic [CFG_DATA_W-1:0] r_term_bytes;
    logic [5:0]            r_skip_count;

    // Frame state
    logic            r_in_frame;
    logic [7:0]      r_bcc;
    logic [FC_W-1:0] r_fc;
    logic [5:0]      r_skipped;
    logic            r_dropped;

    // Held item and result
    logic [7:0] r_pb;
    logic       r_last;
    logic [7:0] r_out_byte;
    logic       r_frame_end;
    logic       r_overflow;

    // Plan signals
    logic                plain;
    logic [FC_W-1:0]     fc0;
    logic [FC_W-1:0]     fc1;
    logic [FC_W-1:0]     room;
    logic                pay_want;
    logic                pay_n;
    logic                pay_drop;
    logic                skip_inc;
    logic [TERM_N_W-1:0] term_lim;
    logic [TERM_N_W-1:0] nterm;
    logic [TERM_N_W-1:0] term_n;
    logic                term_drop;
    logic                term_stop;
    logic [2:0]          hdr_n;
    logic                chk_n;
    logic                ovf;
    logic [7:0]          sel_byte;
    logic [7:0]          g_chr;
    logic [7:0]          l_chr;

    // Plan the step from the held item and frame state
    always_comb begin
        plain    = r_mode;
        fc0      = r_in_frame ? r_fc
                 : (plain ? FC_W'(HDR_LEN_PLAIN) : FC_W'(HDR_LEN_CHECK));
        hdr_n    = r_in_frame ? 3'd0 : (plain ? HDR_LEN_PLAIN : HDR_LEN_CHECK);
        skip_inc = (r_pb != 8'd0) && plain && (r_skipped < r_skip_count);
        pay_want = (r_pb != 8'd0) && !skip_inc;
        pay_n    = pay_want && (fc0 < CAP);
        pay_drop = pay_want && !(fc0 < CAP);
        fc1      = fc0 + FC_W'(pay_n);
        room     = CAP - fc1;

        // Terminator length: stop at the limit or before a zero byte
        term_lim  = (r_term_len < TERM_N_W'(TERM_MAX)) ? r_term_len
                                                       : TERM_N_W'(TERM_MAX);
        nterm     = '0;
        term_stop = 1'b0;
        for (int i = 0; i < TERM_MAX; i++) begin
            if (!term_stop && (TERM_N_W'(i) < term_lim)) begin
                if (r_term_bytes[8*i +: 8] == 8'd0) begin
                    term_stop = 1'b1;
                end else begin
                    nterm = TERM_N_W'(i + 1);
                end
            end
        end
        if (!r_last) begin
            nterm = '0;
        end

        term_drop = ({{(FC_W-TERM_N_W){1'b0}}, nterm} > room);
        term_n    = term_drop ? room[TERM_N_W-1:0] : nterm;
        chk_n     = r_last && !plain;
        ovf       = r_dropped || pay_drop || term_drop;
    end

    assign o_status.hdr_n  = hdr_n;
    assign o_status.pay_n  = pay_n;
    assign o_status.term_n = term_n;
    assign o_status.chk_n  = chk_n;
    assign o_status.total  = TOTAL_W'(hdr_n) + TOTAL_W'(pay_n)
                           + TOTAL_W'(term_n) + TOTAL_W'(chk_n);

    // Select the byte to send
    always_comb begin
        g_chr = CHR_ZERO + {4'd0, r_group};
        l_chr = CHR_ZERO + {4'd0, r_local};
        case (i_cmd.sel)
            SEL_HDR: begin
                case (i_cmd.idx)
                    3'd0:         sel_byte = CHR_EOT;
                    3'd1, 3'd2:   sel_byte = g_chr;
                    3'd3, 3'd4:   sel_byte = l_chr;
                    default:      sel_byte = CHR_STX;
                endcase
            end
            SEL_PAY:  sel_byte = r_pb;
            SEL_TERM: sel_byte = r_term_bytes[{i_cmd.idx, 3'b000} +: 8];
            default:  sel_byte = r_bcc;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group      <= '0;
            r_local      <= '0;
            r_mode       <= 1'b0;
            r_term_len   <= 4'd1;
            r_term_bytes <= CFG_DATA_W'(3);
            r_skip_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GROUP_ADDR: r_group      <= i_cfg_data[3:0];
                REG_LOCAL_ADDR: r_local      <= i_cfg_data[3:0];
                REG_FRAME_MODE: r_mode       <= i_cfg_data[0];
                REG_TERM_LEN:   r_term_len   <= i_cfg_data[3:0];
                REG_TERM_BYTES: r_term_bytes <= i_cfg_data;
                REG_SKIP_COUNT: r_skip_count <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Frame state: check byte accumulates per sent payload or terminator byte, the rest updates at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_bcc      <= '0;
            r_fc       <= '0;
            r_skipped  <= '0;
            r_dropped  <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_in_frame <= 1'b0;
                r_bcc      <= '0;
                r_fc       <= '0;
                r_skipped  <= '0;
                r_dropped  <= 1'b0;
            end else begin
                r_in_frame <= 1'b1;
                r_fc       <= fc1;
                r_skipped  <= r_skipped + 6'(skip_inc);
                r_dropped  <= ovf;
            end
        end else if (i_cmd.emit && (i_cmd.sel == SEL_PAY || i_cmd.sel == SEL_TERM)) begin
            r_bcc <= r_bcc ^ sel_byte;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pb   <= i_in_data.payload_byte;
            r_last <= i_in_data.payload_last;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte  <= sel_byte;
            r_frame_end <= r_last && i_cmd.final_byte;
            r_overflow  <= ovf;
        end
    end

    assign o_out_data.out_byte  = r_out_byte;
    assign o_out_data.frame_end = r_frame_end;
    assign o_out_data.overflow  = r_overflow;

endmodule

// ===== hw/rtl/bfb_ctrl.sv =====
// Controller: handshakes and the walk through header, payload, terminator and check.
module bfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bfb_pkg::t_status  i_status,
    output bfb_pkg::t_cmd     o_cmd
);
    import bfb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_HDR,
        ST_PAY,
        ST_TERM,
        ST_CHK,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [TERM_N_W-1:0] r_idx, n_idx;
    logic [TOTAL_W-1:0]  r_rem, n_rem;
    logic                r_out_valid, n_out_valid;
    logic                slot_free;
    t_cmd                cmd;

    assign slot_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        cmd         = '0;
        cmd.sel     = SEL_HDR;
        cmd.idx     = r_idx[2:0];

        // Drop the result once it transfers
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_PLAN;
                end
            end
            ST_PLAN: begin
                n_rem   = i_status.total;
                n_idx   = '0;
                n_state = (i_status.total == '0) ? ST_DONE : ST_HDR;
            end
            ST_HDR: begin
                if (r_idx < {1'b0, i_status.hdr_n}) begin
                    if (slot_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_HDR;
                        n_idx    = r_idx + 1'b1;
                    end
                end else begin
                    n_state = ST_PAY;
                end
            end
            ST_PAY: begin
                if (i_status.pay_n) begin
                    if (slot_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_PAY;
                        n_idx    = '0;
                        n_state  = ST_TERM;
                    end
                end else begin
                    n_idx   = '0;
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                if (r_idx < i_status.term_n) begin
                    if (slot_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_TERM;
                        n_idx    = r_idx + 1'b1;
                    end
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_status.chk_n) begin
                    if (slot_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_CHK;
                        n_state  = ST_DONE;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.commit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // Count down remaining bytes and mark the final one
        if (cmd.emit) begin
            cmd.final_byte = (r_rem == TOTAL_W'(1));
            n_rem          = r_rem - 1'b1;
            n_out_valid    = 1'b1;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hw/rtl/bisync_frame_builder_unit.sv =====
// Top level of the bisync frame builder: controller plus datapath.
//
//  Channel   Direction  Handshake              Payload
//  in        input      i_in_valid/o_in_stall  i_in_data  (t_in_item)
//  out       output     o_out_valid/i_out_stall o_out_data (t_out_item)
//  cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
// The controller loads an item, plans its step, walks one byte per cycle
// through header, payload, terminator and check phases while the output is
// not stalled, then commits and frees the input. The payload and check
// phases send at most one byte each; an item that sends nothing goes from
// planning straight to commit.
// Reset is synchronous, active low, and restores the register defaults.
// The output register frees as soon as it transfers; a stall holds the walk.
module bisync_frame_builder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bfb_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bfb_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [bfb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bfb_pkg::*;

    t_cmd    cmd;
    t_status status;

    bfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bfb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/bfb_checker.sv =====
// Port checker for the bisync frame builder, bound to the top level.
module bfb_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  bfb_pkg::t_out_item  o_out_data
);
    import bfb_pkg::*;

    // Reset clears the result register
    ap_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // An accepted item keeps the input side busy while it is worked
    ap_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

endmodule

bind bisync_frame_builder_unit bfb_checker u_bfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_bisync_frame_builder_unit.sv =====
// Self-checking testbench for the bisync frame builder: frame prediction and byte-level checks.
`timescale 1ns / 100ps

import bfb_pkg::*;

// Predicts the line bytes of each accepted payload transfer and checks the block's output.
class frame_scoreboard;
    // Register copies
    logic [3:0]  grp_addr;
    logic [3:0]  loc_addr;
    logic        plain_mode;
    logic [3:0]  term_len;
    logic [63:0] term_seq;
    logic [5:0]  skip_n;

    // Frame state
    bit          open;
    logic [7:0]  bcc;
    int          sent_n;
    int          skipped_n;
    bit          dropped;

    t_out_item   step_q[$];
    t_out_item   line_bytes_q[$];

    int errors;
    int items_in;
    int bytes_out;
    int frames_closed;
    int overflow_frames;
    int silent_closes;

    function new();
        grp_addr   = 4'd0;
        loc_addr   = 4'd0;
        plain_mode = 1'b0;
        term_len   = 4'd1;
        term_seq   = 64'd3;
        skip_n     = 6'd0;
        clear_frame();
    endfunction

    function void clear_frame();
        open      = 1'b0;
        bcc       = 8'h00;
        sent_n    = 0;
        skipped_n = 0;
        dropped   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_GROUP_ADDR: grp_addr   = val[3:0];
            REG_LOCAL_ADDR: loc_addr   = val[3:0];
            REG_FRAME_MODE: plain_mode = val[0];
            REG_TERM_LEN:   term_len   = val[3:0];
            REG_TERM_BYTES: term_seq   = val;
            REG_SKIP_COUNT: skip_n     = val[5:0];
            default: ;
        endcase
    endfunction

    function void put(logic [7:0] b);
        t_out_item r;
        r = '0;
        r.out_byte = b;
        step_q.push_back(r);
    endfunction

    // Send a payload or terminator byte only while the frame has room
    function void put_counted(logic [7:0] b);
        if (sent_n < FRAME_CAPACITY) begin
            put(b);
            sent_n++;
            bcc ^= b;
        end else begin
            dropped = 1'b1;
        end
    endfunction

    function void note_input(t_in_item it);
        logic [7:0] g;
        logic [7:0] l;
        logic [7:0] tb;
        int         n_term;
        step_q.delete();
        items_in++;
        // Open the frame with its header
        if (!open) begin
            g = CHR_ZERO + {4'd0, grp_addr};
            l = CHR_ZERO + {4'd0, loc_addr};
            put(CHR_EOT);
            put(g);
            put(g);
            put(l);
            put(l);
            sent_n = HDR_LEN_PLAIN;
            if (!plain_mode) begin
                put(CHR_STX);
                sent_n = HDR_LEN_CHECK;
            end
            open = 1'b1;
        end
        // Drop zero bytes; skip leading bytes in plain mode
        if (it.payload_byte != 8'h00) begin
            if (plain_mode && skipped_n < skip_n)
                skipped_n++;
            else
                put_counted(it.payload_byte);
        end
        // Close: terminator, then block check in checksum mode
        if (it.payload_last) begin
            n_term = (term_len < TERM_MAX) ? term_len : TERM_MAX;
            for (int i = 0; i < n_term; i++) begin
                tb = term_seq[8*i +: 8];
                if (tb == 8'h00)
                    break;
                put_counted(tb);
            end
            if (!plain_mode)
                put(bcc);
        end
        foreach (step_q[k])
            step_q[k].overflow = dropped;
        if (it.payload_last) begin
            frames_closed++;
            if (dropped)
                overflow_frames++;
            if (step_q.size() == 0)
                silent_closes++;
            else
                step_q[step_q.size()-1].frame_end = 1'b1;
            clear_frame();
        end
        foreach (step_q[k])
            line_bytes_q.push_back(step_q[k]);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (line_bytes_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected output, expected none, got byte %h end %b ovf %b",
                     $time, got.out_byte, got.frame_end, got.overflow);
            return;
        end
        want = line_bytes_q.pop_front();
        bytes_out++;
        if (got.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
        end
        if (got.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %b, got %b (byte %h)",
                     $time, want.frame_end, got.frame_end, want.out_byte);
        end
        if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %b, got %b (byte %h)",
                     $time, want.overflow, got.overflow, want.out_byte);
        end
    endfunction

    function int pending();
        return line_bytes_q.size();
    endfunction
endclass

module tb_bisync_frame_builder_unit;

    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_ITEMS   = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_scoreboard sb = new();

    int in_idle_pct  = 25;
    int out_idle_pct = 25;
    int hold_reqs    = 0;
    int sent_items   = 0;

    bisync_frame_builder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watch both channels for transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // Receiver: random stalls, plus a long counted hold-off on request
    initial begin : out_side
        int hold_cnt;
        int seen;
        hold_cnt = 0;
        seen     = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seen != hold_reqs) begin
                seen     = hold_reqs;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d line bytes still expected", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // Offer one payload transfer, idling at random first
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{payload_byte: b, payload_last: last};
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sent_items++;
    endtask

    // Hold the sender until every expected byte is out and the block is idle
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] g, input logic [3:0] l, input logic m,
                              input logic [3:0] tl, input logic [63:0] tb,
                              input logic [5:0] sk);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{REG_GROUP_ADDR, REG_LOCAL_ADDR, REG_FRAME_MODE,
                REG_TERM_LEN, REG_TERM_BYTES, REG_SKIP_COUNT};
        val = '{64'(g), 64'(l), 64'(m), 64'(tl), tb, 64'(sk)};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            sb.write_reg(idx[i], val[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Pick a register setting per phase, forcing the extremes in some phases
    task automatic random_config(input int phase);
        logic [3:0]  g;
        logic [3:0]  l;
        logic [3:0]  tl;
        logic [63:0] tb;
        logic [5:0]  sk;
        g  = (phase == 0) ? 4'd0 : (phase == 1) ? 4'd15 : 4'($urandom_range(15));
        l  = (phase == 0) ? 4'd9 : (phase == 1) ? 4'd0  : 4'($urandom_range(15));
        tl = (phase == 2) ? 4'd8 : (phase == 4) ? 4'd0  :
             (phase == 5) ? 4'd15 : 4'($urandom_range(15));
        for (int i = 0; i < 8; i++) begin
            if (phase != 2 && $urandom_range(5) == 0)
                tb[8*i +: 8] = 8'h00;
            else
                tb[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        if (phase == 5)
            tb = '1;
        sk = (phase == 3) ? 6'd39 : (phase == 5) ? 6'd63 : 6'($urandom_range(7));
        set_config(g, l, phase[0], tl, tb, sk);
    endtask

    // Send a frame of random payload; zero bytes show up now and then
    task automatic send_frame(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            send_item(b, i == len - 1);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: checksum mode, ETX terminator
        send_item(8'h41, 1'b0);
        send_item(8'hFF, 1'b1);
        wait_drain();

        // Zero byte opens the frame; full eight-byte terminator
        set_config(4'd9, 4'd0, 1'b0, 4'd8, 64'h0102_0408_1020_4080, 6'd5);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b1);
        // Frame holding only a zero byte marked last
        send_item(8'h00, 1'b1);
        wait_drain();

        // Plain mode, address digits above 9, no terminator, skipping
        set_config(4'd15, 4'd10, 1'b1, 4'd0, 64'h0, 6'd2);
        send_item(8'h11, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'h33, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h44, 1'b1);
        send_item(8'h55, 1'b0);
        send_item(8'h66, 1'b1);
        wait_drain();

        // Terminator cut short by a zero byte; length above the maximum
        set_config(4'd3, 4'd7, 1'b1, 4'd15, 64'h4142_4344_0045_0D0A, 6'd0);
        send_item(8'h7F, 1'b1);
        wait_drain();

        // Checksum mode ignores the skip count; terminator of eight nonzero bytes
        set_config(4'd1, 4'd2, 1'b0, 4'd15, 64'hFFEE_DDCC_BBAA_9988, 6'd63);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b1);
        send_item(8'h55, 1'b1);
        wait_drain();

        // Random phases of well-formed frames; the no-idle phase has the largest item quota
        for (int phase = 0; phase < 6; phase++) begin
            wait_drain();
            random_config(phase);
            in_idle_pct  = (phase == 4) ? 0 : 25;
            out_idle_pct = (phase == 4) ? 0 : 25;
            if (phase == 2)
                hold_reqs++;
            phase_start = sent_items;
            // Overrun the frame capacity
            if (phase == 2)
                send_frame(100);
            while (sent_items - phase_start <
                   ((phase == 4) ? RAND_ITEMS / 4 : RAND_ITEMS / 8)) begin
                send_frame($urandom_range(1, 6));
                if (phase == 1 || $urandom_range(7) == 0)
                    wait_drain();
            end
        end

        wait_drain();
        $display("Sent %0d payload transfers in %0d frames (%0d overflowed, %0d closed silently)",
                 sb.items_in, sb.frames_closed, sb.overflow_frames, sb.silent_closes);
        $display("Checked %0d line bytes over six register settings plus directed cases",
                 sb.bytes_out);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
